// File: rtl/adpe_pkg.sv
// Shared types, codes and a decode helper for the A32 data-processing execute block.
package adpe_pkg;

  localparam logic [3:0]  CondAlways = 4'd14;
  localparam logic [3:0]  PcIndex    = 4'd15;
  localparam logic [31:0] PcStep     = 32'd4;

  typedef enum logic [1:0] {
    OUT_EXEC     = 2'd0,
    OUT_FALLBACK = 2'd1,
    OUT_NOT_DP   = 2'd2
  } outcome_t;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } alu_op_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] first_operand;
    logic [31:0] second_reg_value;
    logic [3:0]  flags_now;
    logic [31:0] pc_now;
  } req_t;

  typedef struct packed {
    outcome_t    outcome;
    logic        dest_write;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic [3:0]  flags_next;
    logic [31:0] pc_next;
  } rsp_t;

  // Classified transaction handed from the front end to the back end
  typedef struct packed {
    outcome_t    kind;
    alu_op_t     op;
    logic        s_bit;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [3:0]  flags;
    logic        rot_c_en;
    logic        rot_c;
    logic [3:0]  rd;
    logic [31:0] pc;
  } uop_t;

  // Class test from the A32 decode table: true for data-processing words
  function automatic logic is_data_proc(input logic [31:0] w);
    logic [2:0] cls;
    logic       misc;
    logic [3:0] lo;
    logic [1:0] op2;
    logic       res;
    cls  = w[27:25];
    misc = (w[24:23] == 2'b10) && !w[20];
    lo   = w[7:4];
    op2  = w[22:21];
    res  = 1'b1;
    if (cls == 3'd1) begin
      res = !misc;
    end else if (cls != 3'd0) begin
      res = 1'b0;
    end else if (!lo[0]) begin
      res = !(misc && ((lo == 4'd0) || lo[3]));
    end else if (lo[3]) begin
      res = 1'b0;
    end else if (misc) begin
      if ((lo == 4'd1) && ((op2 == 2'd1) || (op2 == 2'd3))) begin
        res = 1'b0;
      end
      if (((lo == 4'd3) || (lo == 4'd7)) && (op2 == 2'd1)) begin
        res = 1'b0;
      end
      if (lo == 4'd5) begin
        res = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/a32_data_op_execute.sv
// Top level of the A32 data-processing execute block.
// Usage:
//   Input: drive req and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. busy rises only when the
//   two-entry queue between front end and back end is full.
//   Output: each transaction yields one result on rsp, marked by done for
//   exactly one cycle; the receiver must take it then.
// Path: the accepting edge writes the transaction into the queue; the back
//   end pops it from there and registers the result together with done.
// Throughput: one transaction per cycle. The front end classifies in the
//   accept cycle, the back end pops one entry and runs the ALU per cycle,
//   so the queue never holds more than one entry and busy stays low.
// Reset: synchronous rst empties the queue and drops done; in-flight
//   transactions are discarded.
// Stalls: the receiver cannot stall, so results are never held back.
module a32_data_op_execute (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  adpe_pkg::req_t req,
  output logic           done,
  output adpe_pkg::rsp_t rsp
);

  adpe_pkg::uop_t front_uop;
  adpe_pkg::uop_t back_uop;
  logic           q_empty;
  logic           q_full;
  logic           accept;
  logic           pop;

  assign busy   = q_full;
  assign accept = start && !q_full;
  assign pop    = !q_empty;

  adpe_front u_front (
    .req (req),
    .uop (front_uop)
  );

  adpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_uop),
    .pop       (pop),
    .pop_data  (back_uop),
    .empty     (q_empty),
    .full      (q_full)
  );

  adpe_back u_back (
    .clk  (clk),
    .rst  (rst),
    .go   (pop),
    .uop  (back_uop),
    .done (done),
    .rsp  (rsp)
  );

endmodule

// File: rtl/adpe_front.sv
// Front end: classifies an accepted instruction and prepares its operands.
module adpe_front (
  input  adpe_pkg::req_t req,
  output adpe_pkg::uop_t uop
);

  logic [31:0] w;
  logic [4:0]  rot;
  logic [63:0] imm_pair;
  logic [31:0] imm_rot;
  logic        shifted;

  assign w        = req.instr_word;
  assign rot      = {w[11:8], 1'b0};
  assign imm_pair = {w[7:0], 24'd0, w[7:0], 24'd0} >> 24;
  assign imm_rot  = 32'(imm_pair >> rot);
  assign shifted  = !w[25] && (w[11:4] != 8'd0);

  // Classify and select the second operand
  always_comb begin
    uop.op        = adpe_pkg::alu_op_t'(w[24:21]);
    uop.s_bit     = w[20];
    uop.opa       = req.first_operand;
    uop.opb       = w[25] ? imm_rot : req.second_reg_value;
    uop.flags     = req.flags_now;
    uop.rot_c_en  = w[25] && w[20] && (rot != 5'd0);
    uop.rot_c     = imm_rot[31];
    uop.rd        = w[15:12];
    uop.pc        = req.pc_now;
    if (w[31:28] != adpe_pkg::CondAlways) begin
      uop.kind = adpe_pkg::OUT_FALLBACK;
    end else if (!adpe_pkg::is_data_proc(w)) begin
      uop.kind = adpe_pkg::OUT_NOT_DP;
    end else if (shifted || (w[15:12] == adpe_pkg::PcIndex)) begin
      uop.kind = adpe_pkg::OUT_FALLBACK;
    end else begin
      uop.kind = adpe_pkg::OUT_EXEC;
    end
  end

endmodule

// File: rtl/adpe_queue.sv
// Two-entry queue between the front end and the back end.
module adpe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  adpe_pkg::uop_t push_data,
  input  logic           pop,
  output adpe_pkg::uop_t pop_data,
  output logic           empty,
  output logic           full
);

  adpe_pkg::uop_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = mem[rd_ptr];

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/adpe_back.sv
// Back end: runs the ALU on a classified transaction and registers the result.
module adpe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  adpe_pkg::uop_t uop,
  output logic           done,
  output adpe_pkg::rsp_t rsp
);

  logic [31:0]    x;
  logic [31:0]    y;
  logic           ci;
  logic [32:0]    sum;
  logic [31:0]    r;
  logic           arith;
  logic           no_dest;
  logic           upd;
  logic [3:0]     f_base;
  logic [3:0]     f_new;
  logic           v;
  adpe_pkg::rsp_t rsp_next;

  // Select adder operands and logic result
  always_comb begin
    x     = uop.opa;
    y     = uop.opb;
    ci    = 1'b0;
    arith = 1'b1;
    case (uop.op)
      adpe_pkg::OP_SUB, adpe_pkg::OP_CMP: begin
        y = ~uop.opb; ci = 1'b1;
      end
      adpe_pkg::OP_RSB: begin
        x = uop.opb; y = ~uop.opa; ci = 1'b1;
      end
      adpe_pkg::OP_ADD, adpe_pkg::OP_CMN: begin
        ci = 1'b0;
      end
      adpe_pkg::OP_ADC: begin
        ci = uop.flags[1];
      end
      adpe_pkg::OP_SBC: begin
        y = ~uop.opb; ci = uop.flags[1];
      end
      adpe_pkg::OP_RSC: begin
        x = uop.opb; y = ~uop.opa; ci = uop.flags[1];
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
  assign v   = (~(x[31] ^ y[31])) & (x[31] ^ sum[31]);

  always_comb begin
    case (uop.op)
      adpe_pkg::OP_AND, adpe_pkg::OP_TST: r = uop.opa & uop.opb;
      adpe_pkg::OP_EOR, adpe_pkg::OP_TEQ: r = uop.opa ^ uop.opb;
      adpe_pkg::OP_ORR:                   r = uop.opa | uop.opb;
      adpe_pkg::OP_MOV:                   r = uop.opb;
      adpe_pkg::OP_BIC:                   r = uop.opa & ~uop.opb;
      adpe_pkg::OP_MVN:                   r = ~uop.opb;
      default:                            r = sum[31:0];
    endcase
  end

  // Build flags and the result record
  assign no_dest = (uop.op == adpe_pkg::OP_TST) || (uop.op == adpe_pkg::OP_TEQ) ||
                   (uop.op == adpe_pkg::OP_CMP) || (uop.op == adpe_pkg::OP_CMN);
  assign upd     = uop.s_bit || no_dest;
  assign f_base  = uop.rot_c_en ? {uop.flags[3:2], uop.rot_c, uop.flags[0]} : uop.flags;

  always_comb begin
    if (!upd) begin
      f_new = f_base;
    end else if (arith) begin
      f_new = {r[31], (r == 32'd0), sum[32], v};
    end else begin
      f_new = {r[31], (r == 32'd0), f_base[1:0]};
    end
  end

  always_comb begin
    rsp_next.outcome    = uop.kind;
    rsp_next.dest_index = uop.rd;
    if (uop.kind == adpe_pkg::OUT_EXEC) begin
      rsp_next.dest_write = !no_dest;
      rsp_next.dest_value = no_dest ? 32'd0 : r;
      rsp_next.flags_next = f_new;
      rsp_next.pc_next    = uop.pc + adpe_pkg::PcStep;
    end else begin
      rsp_next.dest_write = 1'b0;
      rsp_next.dest_value = 32'd0;
      rsp_next.flags_next = uop.flags;
      rsp_next.pc_next    = uop.pc;
    end
  end

  // Register done from go; the result is registered alongside it
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: sim/tb.sv
// Self-checking testbench for the A32 data-processing execute block.
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;

  // Issued transaction paired with the result predicted for it
  typedef struct {
    adpe_pkg::req_t stim;
    adpe_pkg::rsp_t exp;
  } pending_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  adpe_pkg::req_t req;
  logic done;
  adpe_pkg::rsp_t rsp;

  pending_t expected_results[$];
  int       mismatch_count;
  int       stall_cycles = 0;

  a32_data_op_execute DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Add with carry-in; return carry and overflow with the sum
  function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                            input logic cin, output logic cout,
                                            output logic ovf);
    logic [32:0] sum;
    sum  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    cout = sum[32];
    ovf  = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  // Compute the result the execute stage must give for one transaction
  function automatic adpe_pkg::rsp_t predict_exec(input adpe_pkg::req_t r);
    adpe_pkg::rsp_t    e;
    logic [31:0]       w, opa, opb, res;
    logic [3:0]        fl, rd, lo;
    logic [2:0]        cls;
    logic [1:0]        op2;
    logic [4:0]        rot;
    logic              misc, dp, sflag, cin, c, v, arith, writes, upd, ok;
    adpe_pkg::alu_op_t op;
    w     = r.instr_word;
    opa   = r.first_operand;
    fl    = r.flags_now;
    rd    = w[15:12];
    cls   = w[27:25];
    misc  = (w[24:23] == 2'b10) && !w[20];
    lo    = w[7:4];
    op2   = w[22:21];
    sflag = w[20];
    op    = adpe_pkg::alu_op_t'(w[24:21]);
    cin   = fl[1];
    c     = 1'b0;
    v     = 1'b0;
    res   = 32'd0;
    ok    = 1'b1;
    arith = 1'b0;
    writes = 1'b1;
    upd   = sflag;
    e.outcome    = adpe_pkg::OUT_FALLBACK;
    e.dest_write = 1'b0;
    e.dest_index = rd;
    e.dest_value = 32'd0;
    e.flags_next = fl;
    e.pc_next    = r.pc_now;
    // Class the word by the decode table
    if (cls == 3'd1) dp = !misc;
    else if (cls != 3'd0) dp = 1'b0;
    else if (!lo[0]) dp = !(misc && (lo == 4'd0 || lo[3]));
    else if (lo[3]) dp = 1'b0;
    else if (misc) dp = !((lo == 4'd1 && op2[0]) ||
                          ((lo == 4'd3 || lo == 4'd7) && op2 == 2'd1) ||
                          lo == 4'd5);
    else dp = 1'b1;
    if (w[31:28] != adpe_pkg::CondAlways) return e;
    if (!dp) begin
      e.outcome = adpe_pkg::OUT_NOT_DP;
      return e;
    end
    // Form the second operand; a rotated immediate may set carry
    if (w[25]) begin
      rot = {w[11:8], 1'b0};
      opb = {24'd0, w[7:0]};
      if (rot != 5'd0) begin
        opb = 32'(({opb, opb}) >> rot);
        if (sflag) fl[1] = opb[31];
      end
    end else begin
      ok  = (w[11:4] == 8'd0);
      opb = r.second_reg_value;
    end
    if (!ok) return e;
    case (op)
      adpe_pkg::OP_AND: res = opa & opb;
      adpe_pkg::OP_EOR: res = opa ^ opb;
      adpe_pkg::OP_SUB: begin res = add_carry(opa, ~opb, 1'b1, c, v); arith = 1'b1; end
      adpe_pkg::OP_RSB: begin res = add_carry(opb, ~opa, 1'b1, c, v); arith = 1'b1; end
      adpe_pkg::OP_ADD: begin res = add_carry(opa, opb, 1'b0, c, v); arith = 1'b1; end
      adpe_pkg::OP_ADC: begin res = add_carry(opa, opb, cin, c, v); arith = 1'b1; end
      adpe_pkg::OP_SBC: begin res = add_carry(opa, ~opb, cin, c, v); arith = 1'b1; end
      adpe_pkg::OP_RSC: begin res = add_carry(opb, ~opa, cin, c, v); arith = 1'b1; end
      adpe_pkg::OP_TST: begin res = opa & opb; writes = 1'b0; upd = 1'b1; end
      adpe_pkg::OP_TEQ: begin res = opa ^ opb; writes = 1'b0; upd = 1'b1; end
      adpe_pkg::OP_CMP: begin
        res = add_carry(opa, ~opb, 1'b1, c, v);
        arith = 1'b1; writes = 1'b0; upd = 1'b1;
      end
      adpe_pkg::OP_CMN: begin
        res = add_carry(opa, opb, 1'b0, c, v);
        arith = 1'b1; writes = 1'b0; upd = 1'b1;
      end
      adpe_pkg::OP_ORR: res = opa | opb;
      adpe_pkg::OP_MOV: res = opb;
      adpe_pkg::OP_BIC: res = opa & ~opb;
      default: res = ~opb;
    endcase
    if (upd) begin
      if (arith) fl = {res[31], res == 32'd0, c, v};
      else fl[3:2] = {res[31], res == 32'd0};
    end
    if (rd != adpe_pkg::PcIndex) begin
      e.outcome    = adpe_pkg::OUT_EXEC;
      e.dest_write = writes;
      e.dest_value = writes ? res : 32'd0;
      e.flags_next = fl;
      e.pc_next    = r.pc_now + adpe_pkg::PcStep;
    end
    return e;
  endfunction

  // Build an always-condition data-processing word
  function automatic logic [31:0] make_dp(input logic imm, input adpe_pkg::alu_op_t op,
                                          input logic s, input logic [3:0] rn,
                                          input logic [3:0] rd, input logic [11:0] operand2);
    return {adpe_pkg::CondAlways, 2'b00, imm, op, s, rn, rd, operand2};
  endfunction

  // Pick an operand value, leaning on the corners
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic adpe_pkg::req_t make_req(input logic [31:0] w, input logic [31:0] a,
                                              input logic [31:0] b, input logic [3:0] fl);
    adpe_pkg::req_t r;
    r.instr_word       = w;
    r.first_operand    = a;
    r.second_reg_value = b;
    r.flags_now        = fl;
    r.pc_now           = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFC : $urandom;
    return r;
  endfunction

  // Count and print one mismatch
  task automatic report_mismatch(input string what, input logic [31:0] instr,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    $display("%0t: mismatch %s instr=%h got=%h exp=%h", $realtime, what, instr, got, want);
  endtask

  // Drive one transaction and hold it until the block takes it
  task automatic issue_instr(input adpe_pkg::req_t r);
    pending_t p;
    @(negedge clk);
    req   = r;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p.stim = r;
    p.exp  = predict_exec(r);
    expected_results.push_back(p);
  endtask

  // Drop start for a burst of cycles and put noise on the request bus
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      req   = {$urandom, $urandom, $urandom, 4'($urandom), $urandom};
    end
  endtask

  // Stop sending and hold until every expected result has come
  task automatic wait_for_drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin : result_check
    pending_t head;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'(rsp.outcome), 32'd0);
      end else begin
        head = expected_results.pop_front();
        if (rsp.outcome !== head.exp.outcome)
          report_mismatch("outcome", head.stim.instr_word, 32'(rsp.outcome),
                          32'(head.exp.outcome));
        if (rsp.dest_write !== head.exp.dest_write)
          report_mismatch("dest_write", head.stim.instr_word, 32'(rsp.dest_write),
                          32'(head.exp.dest_write));
        if (rsp.dest_index !== head.exp.dest_index)
          report_mismatch("dest_index", head.stim.instr_word, 32'(rsp.dest_index),
                          32'(head.exp.dest_index));
        if (rsp.dest_value !== head.exp.dest_value)
          report_mismatch("dest_value", head.stim.instr_word, rsp.dest_value,
                          head.exp.dest_value);
        if (rsp.flags_next !== head.exp.flags_next)
          report_mismatch("flags_next", head.stim.instr_word, 32'(rsp.flags_next),
                          32'(head.exp.flags_next));
        if (rsp.pc_next !== head.exp.pc_next)
          report_mismatch("pc_next", head.stim.instr_word, rsp.pc_next, head.exp.pc_next);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Every opcode, corner operands, and each fallback and class case
  task automatic test_directed();
    logic [3:0] rd;
    for (int i = 0; i < 16; i++) begin
      rd = (i == 15) ? 4'd0 : 4'(i);
      issue_instr(make_req(make_dp(1'b0, adpe_pkg::alu_op_t'(i), 1'b1, 4'd1, rd, 12'h002),
                           (i % 2 == 1) ? 32'hFFFF_FFFF : 32'h8000_0000,
                           (i % 3 == 0) ? 32'h0 : ((i % 3 == 1) ? 32'h7FFF_FFFF : 32'h1),
                           4'(i)));
    end
    // Rotated immediate sets carry: logical keeps V, arithmetic replaces NZCV
    issue_instr(make_req(make_dp(1'b1, adpe_pkg::OP_MOV, 1'b1, 4'd0, 4'd3, {4'd1, 8'hFF}),
                         32'h0, 32'h0, 4'b0001));
    issue_instr(make_req(make_dp(1'b1, adpe_pkg::OP_ADC, 1'b1, 4'd0, 4'd4, {4'd4, 8'h81}),
                         32'hFFFF_FFFF, 32'h0, 4'b0010));
    // Condition other than always
    issue_instr(make_req(make_dp(1'b0, adpe_pkg::OP_ADD, 1'b1, 4'd0, 4'd2, 12'h003) |
                         32'hF000_0000, 32'h5, 32'h6, 4'b1111));
    // Destination is the program counter
    issue_instr(make_req(make_dp(1'b0, adpe_pkg::OP_CMP, 1'b1, 4'd0, adpe_pkg::PcIndex,
                                 12'h004),
                         32'h10, 32'h10, 4'b0000));
    // Shifted register operand: immediate shift and register shift
    issue_instr(make_req(make_dp(1'b0, adpe_pkg::OP_ORR, 1'b0, 4'd0, 4'd5, 12'h082),
                         32'h1, 32'h2, 4'b0000));
    issue_instr(make_req(make_dp(1'b0, adpe_pkg::OP_AND, 1'b1, 4'd0, 4'd5, 12'h312),
                         32'h1, 32'h2, 4'b0000));
    // Other classes: multiply, load, status read, status write immediate
    issue_instr(make_req(32'hE001_0392, 32'h3, 32'h4, 4'b0101));
    issue_instr(make_req(32'hE590_1000, 32'h3, 32'h4, 4'b0101));
    issue_instr(make_req(32'hE10F_0000, 32'h3, 32'h4, 4'b1010));
    issue_instr(make_req(32'hE320_F000, 32'h3, 32'h4, 4'b1010));
  endtask

  // Mostly well-formed instructions with random content, plus noise
  function automatic logic [31:0] pick_instr();
    logic       imm;
    logic [3:0] rd;
    imm = 1'($urandom_range(0, 1));
    rd  = ($urandom_range(0, 15) == 0) ? adpe_pkg::PcIndex : 4'($urandom_range(0, 14));
    case ($urandom_range(0, 9))
      7: return $urandom;
      8: return {adpe_pkg::CondAlways, 28'($urandom)};
      9: begin
        if ($urandom_range(0, 1) == 1)
          return {4'($urandom), 28'(make_dp(imm, adpe_pkg::alu_op_t'($urandom_range(0, 15)),
                                            1'($urandom), 4'($urandom), rd,
                                            12'($urandom)))};
        return make_dp(1'b0, adpe_pkg::alu_op_t'($urandom_range(0, 15)), 1'($urandom),
                       4'($urandom), rd, {7'($urandom), 1'b0, 4'($urandom)});
      end
      default: begin
        return make_dp(imm, adpe_pkg::alu_op_t'($urandom_range(0, 15)), 1'($urandom),
                       4'($urandom), rd, imm ? 12'($urandom) : {8'h00, 4'($urandom)});
      end
    endcase
  endfunction

  // Random mix with bursts of idle cycles in some stretches and a drain halfway
  task automatic test_random_mix(input int count);
    int gap_odds;
    gap_odds = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) gap_odds = $urandom_range(0, 3);
      if (i == count / 2) wait_for_drain();
      issue_instr(make_req(pick_instr(), pick_value(), pick_value(), 4'($urandom)));
      if (gap_odds != 0 && $urandom_range(0, 3) < gap_odds)
        hold_off($urandom_range(1, 6));
    end
  endtask

  // Back-to-back transactions with no idling
  task automatic test_back_to_back(input int count);
    for (int i = 0; i < count; i++)
      issue_instr(make_req(pick_instr(), pick_value(), pick_value(), 4'($urandom)));
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    req            = '0;
    mismatch_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    hold_off(3);
    wait_for_drain();
    test_random_mix(1200);
    test_back_to_back(300);

    // Drain and let any late result show up
    @(negedge clk);
    start = 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("missing result", expected_results[0].stim.instr_word, 32'd0, 32'd0);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
